>>> design/velocity_command_slew_limiter_unit_assert.svh
// Assertion macros shared by the checker.
`ifndef VELOCITY_COMMAND_SLEW_LIMITER_UNIT_ASSERT_SVH
`define VELOCITY_COMMAND_SLEW_LIMITER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define VCSL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vcsl assertion failed");

// next-cycle implication
`define VCSL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vcsl assertion failed");

`endif

>>> design/vcsl_pkg.sv
`default_nettype none

package vcsl_pkg;

    localparam int VEL_W   = 32;
    localparam int MS_W    = 16;
    localparam int CFG_W   = 31;
    localparam int IDX_W   = 2;
    localparam int REACH_W = MS_W + CFG_W;

    localparam logic [IDX_W-1:0] REG_SMOOTHING_ENABLE = 2'd0;
    localparam logic [IDX_W-1:0] REG_ZERO_AS_DUTY     = 2'd1;
    localparam logic [IDX_W-1:0] REG_RATE_PER_MS      = 2'd2;
    localparam logic [IDX_W-1:0] REG_MIN_CHANGE       = 2'd3;

    localparam logic [CFG_W-1:0] RATE_PER_MS_RESET = 31'd65536;
    localparam logic [CFG_W-1:0] MIN_CHANGE_RESET  = 31'd655;

    typedef struct packed {
        logic signed [VEL_W-1:0] commanded_velocity;
        logic [MS_W-1:0]         elapsed_ms;
    } in_t;

    typedef struct packed {
        logic                    send;
        logic                    duty_zero;
        logic signed [VEL_W-1:0] velocity_out;
    } out_t;

    typedef struct packed {
        logic             smoothing_enable;
        logic             zero_as_duty;
        logic [CFG_W-1:0] rate_per_ms;
        logic [CFG_W-1:0] min_change;
    } cfg_t;

endpackage

`default_nettype wire

>>> design/vcsl_cfg.sv
`default_nettype none

module vcsl_cfg (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [vcsl_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [vcsl_pkg::CFG_W-1:0] cfg_wdata,
    output vcsl_pkg::cfg_t                  cfg
);
    import vcsl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SMOOTHING_ENABLE: cfg_next.smoothing_enable = cfg_wdata[0];
                REG_ZERO_AS_DUTY:     cfg_next.zero_as_duty     = cfg_wdata[0];
                REG_RATE_PER_MS:      cfg_next.rate_per_ms      = cfg_wdata;
                REG_MIN_CHANGE:       cfg_next.min_change       = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.smoothing_enable <= 1'b1;
            cfg_reg.zero_as_duty     <= 1'b1;
            cfg_reg.rate_per_ms      <= RATE_PER_MS_RESET;
            cfg_reg.min_change       <= MIN_CHANGE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> design/vcsl_core.sv
`default_nettype none

module vcsl_core (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      advance,
    input  wire vcsl_pkg::in_t  item,
    input  wire vcsl_pkg::cfg_t cfg,
    output vcsl_pkg::out_t result
);
    import vcsl_pkg::*;

    logic [VEL_W-1:0]   smoothed_reg;
    logic [VEL_W-1:0]   smoothed_next;
    logic [VEL_W-1:0]   last_sent_reg;
    logic [VEL_W-1:0]   last_sent_next;

    logic [VEL_W-1:0]   cmd;
    logic [REACH_W-1:0] reach;
    logic [VEL_W:0]     dist_s;
    logic [VEL_W:0]     dist_abs;
    logic               snap;
    logic [VEL_W:0]     stepped;
    logic [VEL_W-1:0]   slewed;
    logic [VEL_W-1:0]   v;
    logic [VEL_W:0]     chg_s;
    logic [VEL_W:0]     chg;
    logic               v_zero;
    logic               new_zero;
    logic               big_change;
    logic               send;

    always_comb begin
        cmd      = item.commanded_velocity;
        reach    = REACH_W'(item.elapsed_ms) * REACH_W'(cfg.rate_per_ms);
        dist_s   = {cmd[VEL_W-1], cmd} - {smoothed_reg[VEL_W-1], smoothed_reg};
        dist_abs = dist_s[VEL_W] ? (~dist_s + 1'b1) : dist_s;
        snap     = reach >= REACH_W'(dist_abs);
        // not snapped: reach < distance, so it fits in 33 bits
        if (dist_s[VEL_W]) begin
            stepped = {smoothed_reg[VEL_W-1], smoothed_reg} - reach[VEL_W:0];
        end else begin
            stepped = {smoothed_reg[VEL_W-1], smoothed_reg} + reach[VEL_W:0];
        end
        slewed = snap ? cmd : stepped[VEL_W-1:0];
        v      = cfg.smoothing_enable ? slewed : cmd;

        chg_s      = {v[VEL_W-1], v} - {last_sent_reg[VEL_W-1], last_sent_reg};
        chg        = chg_s[VEL_W] ? (~chg_s + 1'b1) : chg_s;
        v_zero     = (v == '0);
        new_zero   = v_zero && (last_sent_reg != '0);
        big_change = chg >= (VEL_W+1)'(cfg.min_change);
        send       = new_zero || big_change;

        result.send         = send;
        result.duty_zero    = send && cfg.zero_as_duty && v_zero;
        result.velocity_out = (send && !(cfg.zero_as_duty && v_zero)) ? v : '0;

        smoothed_next  = (advance && cfg.smoothing_enable) ? slewed : smoothed_reg;
        last_sent_next = (advance && send) ? v : last_sent_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smoothed_reg  <= '0;
            last_sent_reg <= '0;
        end else begin
            smoothed_reg  <= smoothed_next;
            last_sent_reg <= last_sent_next;
        end
    end

endmodule

`default_nettype wire

>>> design/velocity_command_slew_limiter_unit.sv
// Path: an accepted request waits in the input register, then loads the result
//   register when the output is empty or m_ready is high.
// Throughput: 1 request per cycle while m_ready is high; the slew and deadband state updates in one pass.
// Reset (aresetn low, synchronous): both registers empty, smoothed and last sent
//   velocity zero, configuration to its reset values.
`default_nettype none

module velocity_command_slew_limiter_unit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire vcsl_pkg::in_t              s_payload,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output vcsl_pkg::out_t                  m_payload,
    input  wire logic                       cfg_wr_en,
    input  wire logic [vcsl_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [vcsl_pkg::CFG_W-1:0] cfg_wdata
);
    import vcsl_pkg::*;

    cfg_t cfg;
    in_t  in_data_reg;
    logic in_valid_reg;
    logic in_valid_next;
    out_t out_data_reg;
    logic out_valid_reg;
    logic out_valid_next;
    out_t result;
    logic advance;

    vcsl_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vcsl_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_payload;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

endmodule

`default_nettype wire

>>> design/vcsl_checker.sv
`default_nettype none
`include "velocity_command_slew_limiter_unit_assert.svh"

module vcsl_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_ready,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire vcsl_pkg::out_t m_payload
);
    import vcsl_pkg::*;

    `VCSL_ASSERT_NOW(a_ready_when_out_empty, !m_valid, s_ready)
    `VCSL_ASSERT_NOW(a_quiet_result, m_valid && !m_payload.send, !m_payload.duty_zero && m_payload.velocity_out == '0)
    `VCSL_ASSERT_NOW(a_duty_zero_shape, m_valid && m_payload.duty_zero, m_payload.send && m_payload.velocity_out == '0)
    `VCSL_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_payload))

endmodule

bind velocity_command_slew_limiter_unit vcsl_checker u_vcsl_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

`default_nettype wire

>>> tb/sv/velocity_command_slew_limiter_unit_tb.sv
`timescale 1ns / 100ps

module velocity_command_slew_limiter_unit_tb;
    import vcsl_pkg::*;

    localparam logic signed [VEL_W-1:0] VEL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VEL_W-1:0] VEL_MIN = 32'sh8000_0000;
    localparam logic [CFG_W-1:0] CFG_MAX = 31'h7FFF_FFFF;
    localparam logic [MS_W-1:0] MS_MAX = 16'hFFFF;
    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int HOLD_OFF_AFTER = 600;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;

    localparam out_t NO_SEND = '0;
    localparam out_t ZERO_DUTY = '{send: 1'b1, duty_zero: 1'b1, velocity_out: '0};

    typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_e;

    typedef struct {
        row_kind_e        kind;
        logic [IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0] reg_data;
        in_t              req;
        bit               fixed;
        out_t             fixed_cmd;
    } plan_row_t;

    logic             aclk;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    in_t              s_payload = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    out_t             m_payload;
    logic             cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_index = REG_SMOOTHING_ENABLE;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // register mirror and slew state
    logic                    mir_smoothing = 1'b1;
    logic                    mir_zero_duty = 1'b1;
    logic [CFG_W-1:0]        mir_rate = RATE_PER_MS_RESET;
    logic [CFG_W-1:0]        mir_min_change = MIN_CHANGE_RESET;
    logic signed [VEL_W-1:0] smoothed_vel = '0;
    logic signed [VEL_W-1:0] last_sent_vel = '0;

    out_t      expected_commands[$];
    plan_row_t directed_plan[$];

    int mismatch_count = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int sends_seen = 0;
    int zero_duty_seen = 0;
    int writes_done = 0;
    int send_quiet_left = 0;
    int recv_quiet_left = 0;

    velocity_command_slew_limiter_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [VEL_W:0] vel_distance(logic signed [VEL_W-1:0] a,
                                                    logic signed [VEL_W-1:0] b);
        logic signed [VEL_W:0] d;
        d = $signed({a[VEL_W-1], a}) - $signed({b[VEL_W-1], b});
        return (d < 0) ? -d : d;
    endfunction

    function automatic out_t predict_motor_command(in_t req);
        logic signed [VEL_W-1:0] v;
        logic signed [VEL_W-1:0] target;
        logic [REACH_W-1:0]      reach;
        logic [VEL_W:0]          dist_abs;
        logic                    new_zero;
        logic                    big_change;
        out_t                    cmd;
        target = $signed(req.commanded_velocity);
        v = target;
        if (mir_smoothing) begin
            reach = REACH_W'(req.elapsed_ms) * REACH_W'(mir_rate);
            dist_abs = vel_distance(target, smoothed_vel);
            if (reach >= REACH_W'(dist_abs))
                smoothed_vel = target;
            else if (target < smoothed_vel)
                smoothed_vel = smoothed_vel - reach[VEL_W-1:0];
            else
                smoothed_vel = smoothed_vel + reach[VEL_W-1:0];
            v = smoothed_vel;
        end
        new_zero = (v == 0) && (last_sent_vel != 0);
        big_change = vel_distance(v, last_sent_vel) >= {2'b00, mir_min_change};
        cmd = NO_SEND;
        if (new_zero || big_change) begin
            last_sent_vel = v;
            cmd.send = 1'b1;
            if (mir_zero_duty && v == 0)
                cmd.duty_zero = 1'b1;
            else
                cmd.velocity_out = v;
        end
        return cmd;
    endfunction

    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic logic [CFG_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CFG_W'($urandom_range(1, 16));
            2: return CFG_W'($urandom_range(1 << 10, 1 << 18));
            3: return CFG_W'($urandom);
            4: return CFG_MAX;
            default: return RATE_PER_MS_RESET;
        endcase
    endfunction

    function automatic void add_request(logic signed [VEL_W-1:0] vel, logic [MS_W-1:0] ms,
                                        bit fixed = 1'b0, out_t cmd = '0);
        plan_row_t row;
        row.kind = ROW_REQUEST;
        row.reg_idx = REG_SMOOTHING_ENABLE;
        row.reg_data = '0;
        row.req.commanded_velocity = vel;
        row.req.elapsed_ms = ms;
        row.fixed = fixed;
        row.fixed_cmd = cmd;
        directed_plan.push_back(row);
    endfunction

    function automatic void add_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        plan_row_t row;
        row.kind = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_data = data;
        row.req = '0;
        row.fixed = 1'b0;
        row.fixed_cmd = '0;
        directed_plan.push_back(row);
    endfunction

    task automatic offer_request(in_t req, bit fixed, out_t fixed_cmd);
        int   gap_cycles;
        out_t predicted;
        gap_cycles = draw_wait(send_quiet_left);
        if (gap_cycles != 0) begin
            s_valid <= 1'b0;
            repeat (gap_cycles) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= req;
        predicted = predict_motor_command(req);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_commands.push_back(fixed ? fixed_cmd : predicted);
        requests_sent++;
    endtask

    // only with the pipe empty
    task automatic write_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        s_valid <= 1'b0;
        while (expected_commands.size() != 0) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_SMOOTHING_ENABLE: mir_smoothing = data[0];
            REG_ZERO_AS_DUTY:     mir_zero_duty = data[0];
            REG_RATE_PER_MS:      mir_rate = data;
            REG_MIN_CHANGE:       mir_min_change = data;
            default: ;
        endcase
        writes_done++;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin : check_results
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_payload.send)
                sends_seen++;
            if (m_payload.duty_zero)
                zero_duty_seen++;
            if (expected_commands.size() == 0) begin
                $error("unexpected result %p", m_payload);
                mismatch_count++;
            end else begin
                want = expected_commands.pop_front();
                if (m_payload.send !== want.send) begin
                    $error("send: expected %0b, got %0b", want.send, m_payload.send);
                    mismatch_count++;
                end
                if (m_payload.duty_zero !== want.duty_zero) begin
                    $error("duty_zero: expected %0b, got %0b",
                           want.duty_zero, m_payload.duty_zero);
                    mismatch_count++;
                end
                if (m_payload.velocity_out !== want.velocity_out) begin
                    $error("velocity_out: expected %0d, got %0d",
                           want.velocity_out, m_payload.velocity_out);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : drain_results
        int stall;
        int taken;
        bit held;
        taken = 0;
        held = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            // long back-pressure once so the block fills and stalls its input
            if (!held && taken >= HOLD_OFF_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            stall = draw_wait(recv_quiet_left);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
        end
    end

    initial begin : run_stimulus
        in_t                     req;
        logic signed [VEL_W-1:0] last_cmd;
        logic                    en;
        logic                    dz;
        logic [CFG_W-1:0]        rate;
        logic [CFG_W-1:0]        min_chg;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_request('0, '0, 1'b1, NO_SEND);
        add_request(VEL_MAX, MS_MAX, 1'b1, '{send: 1'b1, duty_zero: 1'b0, velocity_out: VEL_MAX});
        add_request(VEL_MIN, MS_MAX);
        add_request(VEL_MIN, MS_MAX);
        add_request(VEL_MIN, '0);
        add_request('0, 16'd1);
        add_request('0, MS_MAX, 1'b1, ZERO_DUTY);
        add_request('0, 16'd5, 1'b1, NO_SEND);
        add_write(REG_SMOOTHING_ENABLE, '0);
        add_request(32'sd300, '0, 1'b1, NO_SEND);
        add_request('0, '0, 1'b1, NO_SEND);
        add_request(32'sd655, '0, 1'b1, '{send: 1'b1, duty_zero: 1'b0, velocity_out: 32'sd655});
        add_write(REG_ZERO_AS_DUTY, '0);
        add_request('0, '0, 1'b1, '{send: 1'b1, duty_zero: 1'b0, velocity_out: '0});
        add_request(-32'sd1, 16'd7);
        add_write(REG_MIN_CHANGE, CFG_MAX);
        add_request(VEL_MIN, '0);
        add_request(VEL_MAX, '0);
        add_request('0, '0);
        add_write(REG_MIN_CHANGE, '0);
        add_write(REG_SMOOTHING_ENABLE, 31'd1);
        add_write(REG_RATE_PER_MS, '0);
        add_write(REG_ZERO_AS_DUTY, 31'd1);
        add_request(32'sd1000, MS_MAX);
        add_request('0, 16'd3);
        add_write(REG_RATE_PER_MS, CFG_MAX);
        add_request(VEL_MIN, MS_MAX);
        add_request(VEL_MAX, 16'd1);
        add_request(VEL_MAX, 16'd2);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_WRITE)
                write_register(directed_plan[i].reg_idx, directed_plan[i].reg_data);
            else
                offer_request(directed_plan[i].req, directed_plan[i].fixed,
                              directed_plan[i].fixed_cmd);
        end

        last_cmd = '0;
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin
                    en = 1'b1;
                    dz = 1'b1;
                    rate = RATE_PER_MS_RESET;
                    min_chg = MIN_CHANGE_RESET;
                end
                1: begin
                    en = 1'b1;
                    dz = 1'b1;
                    rate = CFG_MAX;
                    min_chg = CFG_MAX;
                end
                2: begin
                    en = 1'b0;
                    dz = 1'b0;
                    rate = '0;
                    min_chg = '0;
                end
                default: begin
                    en = ($urandom_range(0, 3) != 0);
                    dz = 1'($urandom_range(0, 1));
                    rate = pick_level();
                    min_chg = pick_level();
                end
            endcase
            write_register(REG_SMOOTHING_ENABLE, CFG_W'(en));
            write_register(REG_ZERO_AS_DUTY, CFG_W'(dz));
            write_register(REG_RATE_PER_MS, rate);
            write_register(REG_MIN_CHANGE, min_chg);

            repeat (PHASE_ITEMS) begin
                // holds let the slew converge and exercise the deadband
                case ($urandom_range(0, 9))
                    0: req.commanded_velocity = $urandom;
                    1: req.commanded_velocity = $urandom_range(0, 1) ? VEL_MAX : VEL_MIN;
                    2: req.commanded_velocity = '0;
                    3, 4, 5: req.commanded_velocity = last_cmd;
                    6: req.commanded_velocity = last_cmd + VEL_W'($urandom_range(0, 4000))
                                                - VEL_W'(2000);
                    default: req.commanded_velocity = VEL_W'($urandom_range(0, 40 << 16))
                                                      - VEL_W'(20 << 16);
                endcase
                case ($urandom_range(0, 7))
                    0: req.elapsed_ms = '0;
                    1: req.elapsed_ms = MS_MAX;
                    2: req.elapsed_ms = MS_W'($urandom);
                    default: req.elapsed_ms = MS_W'($urandom_range(1, 20));
                endcase
                last_cmd = req.commanded_velocity;
                offer_request(req, 1'b0, NO_SEND);
            end
        end

        s_valid <= 1'b0;
        while (expected_commands.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("slew/deadband run: %0d requests, %0d results, %0d sends (%0d as zero duty)",
                 requests_sent, results_seen, sends_seen, zero_duty_seen);
        $display("%0d register writes over %0d phases, %0d field mismatches",
                 writes_done, N_PHASES, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
